// ===== sv/text_console_cursor_engine_core_defines.svh =====
// Assertion macros shared by the text console cursor engine RTL.
// Included by the files that check their own logic; no other dependency.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TCCE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCCE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== sv/tcce_pkg.sv =====
// Shared types and constants of the text console cursor engine.
// No dependencies; used by the interfaces and every module.
package tcce_pkg;

    localparam int CMD_W    = 2;
    localparam int CH_W     = 8;
    localparam int COL_IN_W = 7;
    localparam int ROW_IN_W = 5;
    localparam int POS_W    = 11;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = 16;
    localparam int OP_W     = 3;

    localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

    localparam logic [CH_W-1:0]   CH_BS      = 8'h08;
    localparam logic [CH_W-1:0]   CH_CR      = 8'h0D;
    localparam logic [CH_W-1:0]   CH_LF      = 8'h0A;
    localparam logic [CH_W-1:0]   CH_BLANK   = 8'h00;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    localparam logic [OP_W-1:0] OP_PUT  = 3'd0;
    localparam logic [OP_W-1:0] OP_BS   = 3'd1;
    localparam logic [OP_W-1:0] OP_CR   = 3'd2;
    localparam logic [OP_W-1:0] OP_LF   = 3'd3;
    localparam logic [OP_W-1:0] OP_SET  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLR  = 3'd5;
    localparam logic [OP_W-1:0] OP_READ = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [CH_W-1:0]     ch;
        logic [COL_IN_W-1:0] col;
        logic [ROW_IN_W-1:0] row;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic init;
    } t_back_status;

endpackage

// ===== sv/tcce_in_if.sv =====
// Command channel of the text console cursor engine: valid, ready and one word.
// Depends on tcce_pkg for the field widths.
interface tcce_in_if;
    import tcce_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [CH_W-1:0]     ch;
    logic [COL_IN_W-1:0] col;
    logic [ROW_IN_W-1:0] row;

    modport source (output valid, output cmd, output ch, output col, output row, input ready);
    modport sink   (input valid, input cmd, input ch, input col, input row, output ready);
endinterface

// ===== sv/tcce_out_if.sv =====
// Result channel of the text console cursor engine: valid, ready and one word.
// Depends on tcce_pkg for the field widths.
interface tcce_out_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_pos;
    logic [CH_W-1:0]   cell_char;
    logic [ATTR_W-1:0] cell_attr;

    modport source (output valid, output cursor_pos, output cell_char, output cell_attr,
                    input ready);
    modport sink   (input valid, input cursor_pos, input cell_char, input cell_attr,
                    output ready);
endinterface

// ===== sv/text_console_cursor_engine_core.sv =====
// Top level of the text console cursor engine: APB attribute register, front, queue, back.
// Depends on tcce_pkg, tcce_in_if, tcce_out_if, tcce_front, tcce_queue and tcce_back.
// Each command word yields one result word with the linear cursor position and, for read
// cell, the stored character and attribute. Backspace away from the first column passes
// through S_BSWR and read cell through S_RDWAIT before the result is registered; these steps
// are set by the single write and single registered read port of the screen memory. A scroll
// (line feed or wrap on the bottom row) and clear screen walk the memory one cell per cycle.
// After reset a clearing pass sets every cell; no command word is accepted meanwhile,
// while attribute writes are taken. A two-word queue lets commands be taken while a result
// waits on the output.
`include "text_console_cursor_engine_core_defines.svh"

module text_console_cursor_engine_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcce_in_if.sink     i_req,
    tcce_out_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcce_pkg::*;

    localparam logic REG_ATTR = 1'b0;

    logic [ATTR_W-1:0] r_attr;
    logic              w_reg_idx;
    logic              w_push;
    logic              w_pop;
    t_job              w_push_job;
    t_job              w_pop_job;
    t_q_status         w_q_st;
    t_back_status      w_bst;

    assign w_reg_idx = paddr[2];
    assign pready    = 1'b1;
    assign prdata    = (w_reg_idx == REG_ATTR) ? {24'b0, r_attr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_idx == REG_ATTR) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    tcce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
        .i_req  (i_req),
        .i_q_st (w_q_st),
        .i_init (w_bst.init),
        .o_push (w_push),
        .o_job  (w_push_job)
    );

    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_st    (w_q_st)
    );

    tcce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_attr  (r_attr),
        .i_q_st  (w_q_st),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .o_st    (w_bst),
        .o_rsp   (o_rsp)
    );

    `TCCE_ASSERT_NEVER(a_no_accept_init, i_clk, i_rst_n, w_bst.init && i_req.valid && i_req.ready, "word accepted during clearing pass")

endmodule

// ===== sv/tcce_front.sv =====
// Front end: accepts command words, clamps coordinates and classifies put char.
// Depends on tcce_pkg and tcce_in_if.
module tcce_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    tcce_in_if.sink              i_req,
    input  tcce_pkg::t_q_status  i_q_st,
    input  logic                 i_init,
    output logic                 o_push,
    output tcce_pkg::t_job       o_job
);
    import tcce_pkg::*;

    logic [COL_IN_W-1:0] w_col;
    logic [ROW_IN_W-1:0] w_row;
    logic [OP_W-1:0]     w_op;

    assign i_req.ready = !i_q_st.full && !i_init;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        w_col = i_req.col;
        w_row = i_req.row;
        if (int'(i_req.col) > COLUMNS - 1) begin
            w_col = COL_IN_W'(COLUMNS - 1);
        end
        if (int'(i_req.row) > ROWS - 1) begin
            w_row = ROW_IN_W'(ROWS - 1);
        end
    end

    always_comb begin
        case (i_req.cmd)
            CMD_PUT: begin
                case (i_req.ch)
                    CH_BS:   w_op = OP_BS;
                    CH_CR:   w_op = OP_CR;
                    CH_LF:   w_op = OP_LF;
                    default: w_op = OP_PUT;
                endcase
            end
            CMD_SET:  w_op = OP_SET;
            CMD_CLR:  w_op = OP_CLR;
            CMD_READ: w_op = OP_READ;
            default:  w_op = OP_PUT;
        endcase
    end

    assign o_job = '{op: w_op, ch: i_req.ch, col: w_col, row: w_row};

endmodule

// ===== sv/tcce_queue.sv =====
// Two-entry queue of classified jobs between the front and back ends.
// Depends on tcce_pkg and the assertion macro header.
`include "text_console_cursor_engine_core_defines.svh"

module tcce_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tcce_pkg::t_job       i_job,
    input  logic                 i_pop,
    output tcce_pkg::t_job       o_job,
    output tcce_pkg::t_q_status  o_st
);
    import tcce_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_job      = r_slot[r_rp];
    assign o_st.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_st.empty = (r_cnt == '0);

    `TCCE_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_st.full, "push into full queue")

endmodule

// ===== sv/tcce_back.sv =====
// Back end: cursor state, screen memory, scroll and clear sweeps, result register.
// Depends on tcce_pkg, tcce_out_if and the assertion macro header.
`include "text_console_cursor_engine_core_defines.svh"

module tcce_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [7:0]              i_attr,
    input  tcce_pkg::t_q_status     i_q_st,
    input  tcce_pkg::t_job          i_job,
    output logic                    o_pop,
    output tcce_pkg::t_back_status  o_st,
    tcce_out_if.source              o_rsp
);
    import tcce_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_BSWR   = 4'd3;
    localparam logic [3:0] S_RDWAIT = 4'd4;
    localparam logic [3:0] S_COPY   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_SWEEP  = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic [3:0]        r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic              r_cp_vld, n_cp_vld;
    logic [ADDR_W-1:0] r_cp_dst, n_cp_dst;
    logic [CELL_W-1:0] r_fill, n_fill;
    t_job              r_job, n_job;
    logic [CH_W-1:0]   r_cell_char, n_cell_char;
    logic [ATTR_W-1:0] r_cell_attr, n_cell_attr;
    logic              r_out_vld, n_out_vld;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic [CH_W-1:0]   r_out_char, n_out_char;
    logic [ATTR_W-1:0] r_out_attr, n_out_attr;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [LIN_W-1:0]  w_cur_lin;
    logic [LIN_W-1:0]  w_job_lin;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [ADDR_W-1:0] w_bs_addr;
    logic              w_last_ptr;

    assign w_cur_lin  = LIN_W'(r_row) * LIN_W'(COLUMNS) + LIN_W'(r_col);
    assign w_job_lin  = LIN_W'(r_job.row) * LIN_W'(COLUMNS) + LIN_W'(r_job.col);
    assign w_cur_addr = w_cur_lin[ADDR_W-1:0];
    assign w_bs_addr  = w_cur_addr - ADDR_W'(1);
    assign w_last_ptr = (r_ptr == ADDR_W'(CELLS - 1));

    assign o_pop   = (r_state == S_IDLE) && !i_q_st.empty;
    assign o_st.init = (r_state == S_INIT);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = r_fill;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = {ATTR_RESET, CH_BLANK};
            end
            S_SWEEP: begin
                w_we = 1'b1;
            end
            S_EXEC: begin
                w_we    = (r_job.op == OP_PUT);
                w_waddr = w_cur_addr;
                w_wdata = {i_attr, r_job.ch};
            end
            S_BSWR: begin
                w_we    = 1'b1;
                w_waddr = w_cur_addr;
                w_wdata = {r_rdata[CELL_W-1:CH_W], CH_BLANK};
            end
            S_COPY: begin
                w_we    = r_cp_vld;
                w_waddr = r_cp_dst;
                w_wdata = r_rdata;
            end
            S_DRAIN: begin
                w_we    = 1'b1;
                w_waddr = r_cp_dst;
                w_wdata = r_rdata;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (r_state == S_COPY) begin
            w_raddr = r_ptr;
        end else if (r_job.op == OP_READ) begin
            w_raddr = w_job_lin[ADDR_W-1:0];
        end else begin
            w_raddr = w_bs_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_ptr       = r_ptr;
        n_cp_vld    = 1'b0;
        n_cp_dst    = r_cp_dst;
        n_fill      = r_fill;
        n_job       = r_job;
        n_cell_char = r_cell_char;
        n_cell_attr = r_cell_attr;
        n_out_vld   = r_out_vld && !o_rsp.ready;
        n_out_pos   = r_out_pos;
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;
        case (r_state)
            S_INIT: begin
                if (w_last_ptr) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_job   = i_job;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cell_char = '0;
                n_cell_attr = '0;
                n_state     = S_RESULT;
                case (r_job.op)
                    OP_PUT, OP_LF: begin
                        if (r_job.op == OP_LF || r_col == COL_W'(COLUMNS - 1)) begin
                            n_col = '0;
                            if (r_row == ROW_W'(ROWS - 1)) begin
                                n_ptr   = ADDR_W'(COLUMNS);
                                n_fill  = {i_attr, CH_BLANK};
                                n_state = S_COPY;
                            end else begin
                                n_row = r_row + ROW_W'(1);
                            end
                        end else begin
                            n_col = r_col + COL_W'(1);
                        end
                    end
                    OP_BS: begin
                        if (r_col != '0) begin
                            n_col   = r_col - COL_W'(1);
                            n_state = S_BSWR;
                        end
                    end
                    OP_CR: begin
                        n_col = '0;
                    end
                    OP_SET: begin
                        n_col = COL_W'(r_job.col);
                        n_row = ROW_W'(r_job.row);
                    end
                    OP_CLR: begin
                        n_col   = '0;
                        n_row   = '0;
                        n_ptr   = '0;
                        n_fill  = {i_attr, CH_BLANK};
                        n_state = S_SWEEP;
                    end
                    OP_READ: begin
                        n_state = S_RDWAIT;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_BSWR: begin
                n_state = S_RESULT;
            end
            S_RDWAIT: begin
                n_cell_char = r_rdata[CH_W-1:0];
                n_cell_attr = r_rdata[CELL_W-1:CH_W];
                n_state     = S_RESULT;
            end
            S_COPY: begin
                n_cp_vld = 1'b1;
                n_cp_dst = r_ptr - ADDR_W'(COLUMNS);
                if (w_last_ptr) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                n_ptr   = ADDR_W'(CELLS - COLUMNS);
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (w_last_ptr) begin
                    n_state = S_RESULT;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            S_RESULT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_pos  = w_cur_lin[POS_W-1:0];
                    n_out_char = r_cell_char;
                    n_out_attr = r_cell_attr;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_col     <= '0;
            r_row     <= '0;
            r_ptr     <= '0;
            r_cp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_ptr     <= n_ptr;
            r_cp_vld  <= n_cp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_dst    <= n_cp_dst;
        r_fill      <= n_fill;
        r_job       <= n_job;
        r_cell_char <= n_cell_char;
        r_cell_attr <= n_cell_attr;
        r_out_pos   <= n_out_pos;
        r_out_char  <= n_out_char;
        r_out_attr  <= n_out_attr;
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.cursor_pos = r_out_pos;
    assign o_rsp.cell_char  = r_out_char;
    assign o_rsp.cell_attr  = r_out_attr;

    // The row copy of a scroll must never land on the bottom line.
    `TCCE_ASSERT(a_copy_dst, i_clk, i_rst_n, (r_state == S_DRAIN || r_cp_vld) |-> (r_cp_dst < ADDR_W'(CELLS - COLUMNS)), "scroll copy hit bottom row")
    `TCCE_ASSERT(a_cursor_range, i_clk, i_rst_n, (r_state == S_IDLE) |-> (r_col <= COL_W'(COLUMNS - 1) && r_row <= ROW_W'(ROWS - 1)), "cursor out of screen")

endmodule
